>>> hw/rtl/jet_width_and_pt_dispersion_unit_defines.svh
// Assertion macros for the jet width and ptD unit checker.
// Needs a clk and an rst_n in scope at the point of use.
`ifndef JET_WIDTH_AND_PT_DISPERSION_UNIT_DEFINES_SVH
`define JET_WIDTH_AND_PT_DISPERSION_UNIT_DEFINES_SVH

// Checked only outside reset.
`define JWPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define JWPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/jwpd_pkg.sv
// Shared types, widths and saturating adders for the jet width and ptD unit.
// No dependencies.
package jwpd_pkg;

    localparam int NCLASS      = 3;
    localparam int PT_BITS     = 16;
    localparam int ANGLE_BITS  = 12;
    localparam int ASQ_BITS    = 2 * ANGLE_BITS - 1;
    localparam int PT2_BITS    = 2 * PT_BITS;
    localparam int PROD_BITS   = PT2_BITS + ASQ_BITS;
    localparam int MOM_BITS    = 60;
    localparam int PT2S_BITS   = 38;
    localparam int PTS_BITS    = 22;
    localparam int PTS2_BITS   = 2 * PTS_BITS;
    localparam int TRACE_BITS  = MOM_BITS + 1;
    localparam int WIDTH_FBITS = 16;
    localparam int PTD_FBITS   = 32;
    localparam int NUM_BITS    = TRACE_BITS + WIDTH_FBITS;
    localparam int SQ_IN_BITS  = 62;
    localparam int ROOT_BITS   = SQ_IN_BITS / 2;
    localparam int SQ_REM_BITS = ROOT_BITS + 2;
    localparam int W_BITS      = 20;
    localparam int PTD_BITS    = 17;
    localparam int DIV_STEPS   = NUM_BITS;
    localparam int SQRT_STEPS  = ROOT_BITS;
    localparam int CNT_BITS    = $clog2(DIV_STEPS + 1);
    localparam int Q_DEPTH     = 2;
    localparam int QPTR_BITS   = $clog2(Q_DEPTH);
    localparam int QCNT_BITS   = $clog2(Q_DEPTH + 1);

    // class index of the sums, and the job index of ptD
    localparam logic [1:0] CLS_ALL     = 2'd0;
    localparam logic [1:0] CLS_CHARGED = 2'd1;
    localparam logic [1:0] CLS_NEUTRAL = 2'd2;
    localparam logic [1:0] JOB_PTD     = 2'd3;

    typedef struct packed {
        logic [NCLASS-1:0][MOM_BITS-1:0]  eta;
        logic [NCLASS-1:0][MOM_BITS-1:0]  phi;
        logic [NCLASS-1:0][PT2S_BITS-1:0] pt2;
        logic [PTS_BITS-1:0]              pt;
    } jwpd_sums_t;

    function automatic logic [MOM_BITS-1:0] sat_add_mom(
        input logic [MOM_BITS-1:0]  a,
        input logic [PROD_BITS-1:0] b);
        logic [MOM_BITS:0] s;
        s = {1'b0, a} + {{(MOM_BITS + 1 - PROD_BITS){1'b0}}, b};
        return s[MOM_BITS] ? {MOM_BITS{1'b1}} : s[MOM_BITS-1:0];
    endfunction

    function automatic logic [PT2S_BITS-1:0] sat_add_pt2(
        input logic [PT2S_BITS-1:0] a,
        input logic [PT2_BITS-1:0]  b);
        logic [PT2S_BITS:0] s;
        s = {1'b0, a} + {{(PT2S_BITS + 1 - PT2_BITS){1'b0}}, b};
        return s[PT2S_BITS] ? {PT2S_BITS{1'b1}} : s[PT2S_BITS-1:0];
    endfunction

    function automatic logic [PTS_BITS-1:0] sat_add_pt(
        input logic [PTS_BITS-1:0] a,
        input logic [PT_BITS-1:0]  b);
        logic [PTS_BITS:0] s;
        s = {1'b0, a} + {{(PTS_BITS + 1 - PT_BITS){1'b0}}, b};
        return s[PTS_BITS] ? {PTS_BITS{1'b1}} : s[PTS_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/jwpd_front.sv
// Front end: takes constituent requests, squares and weights them, and keeps
// the per-jet sums. Depends on jwpd_pkg.
module jwpd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [jwpd_pkg::PT_BITS-1:0]    constituent_pt,
    input  logic signed [jwpd_pkg::ANGLE_BITS-1:0] delta_eta,
    input  logic signed [jwpd_pkg::ANGLE_BITS-1:0] delta_phi,
    input  logic                            is_charged,
    input  logic                            is_neutral,
    input  logic                            last_constituent,
    input  logic                            q_full,
    output logic                            q_push,
    output jwpd_pkg::jwpd_sums_t            q_data
);

    logic [jwpd_pkg::ANGLE_BITS-1:0] eta_mag, phi_mag;
    logic [2*jwpd_pkg::ANGLE_BITS-1:0] eta_sq_full, phi_sq_full;
    logic advance;

    // stage 1: squares
    logic                            p1_valid_reg;
    logic [jwpd_pkg::PT_BITS-1:0]    p1_pt_reg;
    logic [jwpd_pkg::PT2_BITS-1:0]   p1_pt2_reg;
    logic [jwpd_pkg::ASQ_BITS-1:0]   p1_eta2_reg, p1_phi2_reg;
    logic [jwpd_pkg::NCLASS-1:0]     p1_member_reg;
    logic                            p1_last_reg;

    // stage 2: weighted moments
    logic                            p2_valid_reg;
    logic [jwpd_pkg::PT_BITS-1:0]    p2_pt_reg;
    logic [jwpd_pkg::PT2_BITS-1:0]   p2_pt2_reg;
    logic [jwpd_pkg::PROD_BITS-1:0]  p2_me_reg, p2_mp_reg;
    logic [jwpd_pkg::NCLASS-1:0]     p2_member_reg;
    logic                            p2_last_reg;

    jwpd_pkg::jwpd_sums_t sums_reg, sums_next, sums_add;

    assign eta_mag = delta_eta[jwpd_pkg::ANGLE_BITS-1] ? (~delta_eta + 1'b1) : delta_eta;
    assign phi_mag = delta_phi[jwpd_pkg::ANGLE_BITS-1] ? (~delta_phi + 1'b1) : delta_phi;
    assign eta_sq_full = eta_mag * eta_mag;
    assign phi_sq_full = phi_mag * phi_mag;

    // hold the whole pipe only when a finished jet finds the queue full
    assign advance  = !(p2_valid_reg && p2_last_reg && q_full);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_pt_reg     <= constituent_pt;
            p1_pt2_reg    <= constituent_pt * constituent_pt;
            p1_eta2_reg   <= eta_sq_full[jwpd_pkg::ASQ_BITS-1:0];
            p1_phi2_reg   <= phi_sq_full[jwpd_pkg::ASQ_BITS-1:0];
            p1_member_reg <= {is_neutral, is_charged, 1'b1};
            p1_last_reg   <= last_constituent;
            p2_pt_reg     <= p1_pt_reg;
            p2_pt2_reg    <= p1_pt2_reg;
            p2_me_reg     <= p1_pt2_reg * p1_eta2_reg;
            p2_mp_reg     <= p1_pt2_reg * p1_phi2_reg;
            p2_member_reg <= p1_member_reg;
            p2_last_reg   <= p1_last_reg;
        end
    end

    always_comb
    begin
        sums_add = sums_reg;
        for (int k = 0; k < jwpd_pkg::NCLASS; k++)
        begin
            if (p2_member_reg[k])
            begin
                sums_add.eta[k] = jwpd_pkg::sat_add_mom(sums_reg.eta[k], p2_me_reg);
                sums_add.phi[k] = jwpd_pkg::sat_add_mom(sums_reg.phi[k], p2_mp_reg);
                sums_add.pt2[k] = jwpd_pkg::sat_add_pt2(sums_reg.pt2[k], p2_pt2_reg);
            end
        end
        sums_add.pt = jwpd_pkg::sat_add_pt(sums_reg.pt, p2_pt_reg);
    end

    assign q_push = advance && p2_valid_reg && p2_last_reg;
    assign q_data = sums_add;

    always_comb
    begin
        sums_next = sums_reg;
        if (advance && p2_valid_reg)
            sums_next = p2_last_reg ? '0 : sums_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sums_reg <= '0;
        else
            sums_reg <= sums_next;
    end

endmodule

>>> hw/rtl/jwpd_queue.sv
// Short queue of finished jet sums between front and back.
// Depends on jwpd_pkg.
module jwpd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jwpd_pkg::jwpd_sums_t push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 empty,
    output jwpd_pkg::jwpd_sums_t head
);

    jwpd_pkg::jwpd_sums_t entry_reg [jwpd_pkg::Q_DEPTH];
    logic [jwpd_pkg::QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [jwpd_pkg::QCNT_BITS-1:0] count_reg, count_next;

    assign full  = (count_reg == jwpd_pkg::QCNT_BITS'(jwpd_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_data;
    end

endmodule

>>> hw/rtl/jwpd_back.sv
// Back end: one shared restoring divider and one digit-by-digit square root,
// run four times per jet, plus the result register. Depends on jwpd_pkg.
module jwpd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  jwpd_pkg::jwpd_sums_t          q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [jwpd_pkg::W_BITS-1:0]   total_width,
    output logic [jwpd_pkg::W_BITS-1:0]   charged_width,
    output logic [jwpd_pkg::W_BITS-1:0]   neutral_width,
    output logic [jwpd_pkg::PTD_BITS-1:0] pt_dispersion,
    output logic                          total_valid,
    output logic                          charged_valid,
    output logic                          neutral_valid,
    output logic                          dispersion_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_CLAMP = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_STORE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam int NB = jwpd_pkg::NUM_BITS;
    localparam int DB = jwpd_pkg::PTS2_BITS;
    localparam int SB = jwpd_pkg::SQ_IN_BITS;
    localparam int RB = jwpd_pkg::ROOT_BITS;
    localparam int QB = jwpd_pkg::SQ_REM_BITS;
    localparam logic [NB-1:0] CAP_W   = NB'(1) << (jwpd_pkg::MOM_BITS);
    localparam logic [NB-1:0] CAP_PTD = NB'(1) << (jwpd_pkg::PTD_FBITS);
    localparam logic [RB-1:0] W_MAX   = RB'((1 << jwpd_pkg::W_BITS) - 1);
    localparam logic [RB-1:0] PTD_MAX = RB'(1 << (jwpd_pkg::PTD_BITS - 1));

    logic [2:0]                     state_reg;
    logic [1:0]                     job_reg;
    logic [1:0]                     cls;
    logic                           job_ok_reg;
    logic [jwpd_pkg::CNT_BITS-1:0]  cnt_reg;
    jwpd_pkg::jwpd_sums_t           sums_reg;
    logic [NB-1:0]                  num_reg, quo_reg, cap;
    logic [DB-1:0]                  den_reg, den_load;
    logic [DB-1:0]                  rem_reg;
    logic [DB:0]                    rem_shift, div_diff;
    logic                           div_ge;
    logic [jwpd_pkg::TRACE_BITS-1:0] trace;
    logic [NB-1:0]                  num_load;
    logic [SB-1:0]                  sq_in_reg;
    logic [QB-1:0]                  sq_rem_reg;
    logic [QB+1:0]                  sq_shift, sq_trial, sq_diff;
    logic                           sq_ge;
    logic [RB-1:0]                  root_reg;
    logic [jwpd_pkg::W_BITS-1:0]    w_res_reg [jwpd_pkg::NCLASS];
    logic [jwpd_pkg::PTD_BITS-1:0]  ptd_res_reg;
    logic [3:0]                     ok_res_reg;
    logic                           out_free;

    logic                           out_valid_reg;
    logic [jwpd_pkg::W_BITS-1:0]    total_width_reg, charged_width_reg, neutral_width_reg;
    logic [jwpd_pkg::PTD_BITS-1:0]  pt_dispersion_reg;
    logic [3:0]                     ok_out_reg;

    assign cls   = (job_reg == jwpd_pkg::JOB_PTD) ? jwpd_pkg::CLS_ALL : job_reg;
    assign trace = {1'b0, sums_reg.eta[cls]} + {1'b0, sums_reg.phi[cls]};

    always_comb
    begin
        if (job_reg == jwpd_pkg::JOB_PTD)
        begin
            num_load = {{(NB - jwpd_pkg::PT2S_BITS - jwpd_pkg::PTD_FBITS){1'b0}},
                        sums_reg.pt2[jwpd_pkg::CLS_ALL], {jwpd_pkg::PTD_FBITS{1'b0}}};
            den_load = sums_reg.pt * sums_reg.pt;
            cap      = CAP_PTD;
        end
        else
        begin
            num_load = {trace, {jwpd_pkg::WIDTH_FBITS{1'b0}}};
            den_load = {{(DB - jwpd_pkg::PT2S_BITS){1'b0}}, sums_reg.pt2[cls]};
            cap      = CAP_W;
        end
    end

    assign rem_shift = {rem_reg, num_reg[NB-1]};
    assign div_diff  = rem_shift - {1'b0, den_reg};
    assign div_ge    = (rem_shift >= {1'b0, den_reg});

    assign sq_shift = {sq_rem_reg, sq_in_reg[SB-1 -: 2]};
    assign sq_trial = {{(QB + 2 - RB - 2){1'b0}}, root_reg, 2'b01};
    assign sq_diff  = sq_shift - sq_trial;
    assign sq_ge    = (sq_shift >= sq_trial);

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    cnt_reg   <= '0;
                    // zero divisor: skip straight to a zero result
                    state_reg <= (den_load == '0) ? S_STORE : S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == jwpd_pkg::CNT_BITS'(jwpd_pkg::DIV_STEPS - 1))
                        state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == jwpd_pkg::CNT_BITS'(jwpd_pkg::SQRT_STEPS - 1))
                        state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    if (job_reg == jwpd_pkg::JOB_PTD)
                        state_reg <= S_OUT;
                    else
                    begin
                        job_reg   <= job_reg + 1'b1;
                        state_reg <= S_LOAD;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            sums_reg <= q_head;
        if (state_reg == S_LOAD)
        begin
            num_reg    <= num_load;
            den_reg    <= den_load;
            rem_reg    <= '0;
            quo_reg    <= '0;
            root_reg   <= '0;
            job_ok_reg <= (den_load != '0);
        end
        if (state_reg == S_DIV)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= div_ge ? div_diff[DB-1:0] : rem_shift[DB-1:0];
            quo_reg <= {quo_reg[NB-2:0], div_ge};
        end
        if (state_reg == S_CLAMP)
        begin
            sq_in_reg  <= (quo_reg > cap) ? cap[SB-1:0] : quo_reg[SB-1:0];
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end
        if (state_reg == S_SQRT)
        begin
            sq_in_reg  <= sq_in_reg << 2;
            sq_rem_reg <= sq_ge ? sq_diff[QB-1:0] : sq_shift[QB-1:0];
            root_reg   <= {root_reg[RB-2:0], sq_ge};
        end
        if (state_reg == S_STORE)
        begin
            ok_res_reg[job_reg] <= job_ok_reg;
            if (job_reg == jwpd_pkg::JOB_PTD)
                ptd_res_reg <= !job_ok_reg ? '0 :
                               (root_reg > PTD_MAX) ? PTD_MAX[jwpd_pkg::PTD_BITS-1:0] :
                               root_reg[jwpd_pkg::PTD_BITS-1:0];
            else
                w_res_reg[cls] <= !job_ok_reg ? '0 :
                                  (root_reg > W_MAX) ? W_MAX[jwpd_pkg::W_BITS-1:0] :
                                  root_reg[jwpd_pkg::W_BITS-1:0];
        end
    end

    // result register: hold while stalled, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            total_width_reg   <= w_res_reg[jwpd_pkg::CLS_ALL];
            charged_width_reg <= w_res_reg[jwpd_pkg::CLS_CHARGED];
            neutral_width_reg <= w_res_reg[jwpd_pkg::CLS_NEUTRAL];
            pt_dispersion_reg <= ptd_res_reg;
            ok_out_reg        <= ok_res_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign total_width      = total_width_reg;
    assign charged_width    = charged_width_reg;
    assign neutral_width    = neutral_width_reg;
    assign pt_dispersion    = pt_dispersion_reg;
    assign total_valid      = ok_out_reg[jwpd_pkg::CLS_ALL];
    assign charged_valid    = ok_out_reg[jwpd_pkg::CLS_CHARGED];
    assign neutral_valid    = ok_out_reg[jwpd_pkg::CLS_NEUTRAL];
    assign dispersion_valid = ok_out_reg[jwpd_pkg::JOB_PTD];

endmodule

>>> hw/rtl/jet_width_and_pt_dispersion_unit.sv
// Top level of the jet width and ptD unit: front, queue and back.
// Depends on jwpd_pkg, jwpd_front, jwpd_queue and jwpd_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one constituent request per
//   cycle: pt, eta and phi offsets, charged and neutral flags and a
//   last_constituent marker. The front takes one request every cycle when
//   not stalled; it squares, weights and accumulates in three stages.
//   On the last constituent the front pushes the jet's sums into a two-entry
//   queue and clears them, so the next jet streams in without a gap.
//   The back pops one jet and runs four jobs (three widths, then ptD), each a
//   77-step restoring division and a 31-step square root on one shared
//   unit, then hands the results to the result register before it pops
//   the next jet. A constituent stream runs at one request per cycle as
//   long as the back keeps pace with the jets; short jets fill the queue
//   and then in_stall rises until the back frees an entry.
//   Output channel (out_valid / out_stall): results wait in a register;
//   while out_stall is high the result holds and the back waits.
//   Reset (rst_n low, asynchronous) empties the pipe and queue and clears
//   the front's sums; no request is pending afterwards.
module jet_width_and_pt_dispersion_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [jwpd_pkg::PT_BITS-1:0]          constituent_pt,
    input  logic signed [jwpd_pkg::ANGLE_BITS-1:0] delta_eta,
    input  logic signed [jwpd_pkg::ANGLE_BITS-1:0] delta_phi,
    input  logic                                  is_charged,
    input  logic                                  is_neutral,
    input  logic                                  last_constituent,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [jwpd_pkg::W_BITS-1:0]           total_width,
    output logic [jwpd_pkg::W_BITS-1:0]           charged_width,
    output logic [jwpd_pkg::W_BITS-1:0]           neutral_width,
    output logic [jwpd_pkg::PTD_BITS-1:0]         pt_dispersion,
    output logic                                  total_valid,
    output logic                                  charged_valid,
    output logic                                  neutral_valid,
    output logic                                  dispersion_valid
);

    // finished-jet hand-over between front and back
    logic                 q_full, q_empty, q_push, q_pop;
    jwpd_pkg::jwpd_sums_t q_data, q_head;

    jwpd_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .constituent_pt   (constituent_pt),
        .delta_eta        (delta_eta),
        .delta_phi        (delta_phi),
        .is_charged       (is_charged),
        .is_neutral       (is_neutral),
        .last_constituent (last_constituent),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_data)
    );

    jwpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    jwpd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .total_width      (total_width),
        .charged_width    (charged_width),
        .neutral_width    (neutral_width),
        .pt_dispersion    (pt_dispersion),
        .total_valid      (total_valid),
        .charged_valid    (charged_valid),
        .neutral_valid    (neutral_valid),
        .dispersion_valid (dispersion_valid)
    );

endmodule

>>> hw/rtl/jwpd_checker.sv
// Port-level checks for the jet width and ptD unit, bound to the top level.
// Depends on jwpd_pkg and jet_width_and_pt_dispersion_unit_defines.svh.
`include "jet_width_and_pt_dispersion_unit_defines.svh"

module jwpd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [jwpd_pkg::W_BITS-1:0]   total_width,
    input logic [jwpd_pkg::W_BITS-1:0]   charged_width,
    input logic [jwpd_pkg::W_BITS-1:0]   neutral_width,
    input logic [jwpd_pkg::PTD_BITS-1:0] pt_dispersion,
    input logic                          total_valid,
    input logic                          charged_valid,
    input logic                          neutral_valid,
    input logic                          dispersion_valid
);

    // a stalled result holds its total and charged widths and its ptD
    `JWPD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(total_width) && $stable(pt_dispersion) && $stable(charged_width), "result changed under stall")

    // an empty class reports zero
    `JWPD_ASSERT(a_zero_when_empty, out_valid |-> (total_valid || total_width == '0) && (charged_valid || charged_width == '0) && (neutral_valid || neutral_width == '0) && (dispersion_valid || pt_dispersion == '0), "empty class gave nonzero")

    // a charged or neutral hit implies a total hit, which implies a pt sum
    `JWPD_ASSERT(a_class_nesting, out_valid && (charged_valid || neutral_valid || total_valid) |-> total_valid && dispersion_valid, "class valid bits inconsistent")

    // ptD never exceeds one
    `JWPD_ASSERT_ALWAYS(a_ptd_range, !out_valid || pt_dispersion <= 17'h10000, "ptD out of range")

endmodule

bind jet_width_and_pt_dispersion_unit jwpd_checker u_jwpd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .total_width      (total_width),
    .charged_width    (charged_width),
    .neutral_width    (neutral_width),
    .pt_dispersion    (pt_dispersion),
    .total_valid      (total_valid),
    .charged_valid    (charged_valid),
    .neutral_valid    (neutral_valid),
    .dispersion_valid (dispersion_valid)
);

>>> tb/sv/jet_width_and_pt_dispersion_unit_test.sv
// Self-checking testbench for jet_width_and_pt_dispersion_unit: streams jets of
// constituents, predicts widths and ptD in-house and checks every result.
// Depends on jwpd_pkg and the unit under test.
module jet_width_and_pt_dispersion_unit_test;
    import jwpd_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int IDLE_LIMIT    = 20000;  // several jet times of the back end
    localparam int SETTLE_CYCLES = 600;    // beyond the jet latency
    localparam int RANDOM_ITEMS  = 1280;
    localparam int MIN_JETS      = 48;
    localparam int N_DIRECTED    = 20;

    localparam longint unsigned MOM_SAT   = (64'd1 << MOM_BITS) - 1;
    localparam longint unsigned PT2_SAT   = (64'd1 << PT2S_BITS) - 1;
    localparam longint unsigned PTSUM_SAT = (64'd1 << PTS_BITS) - 1;
    localparam longint unsigned WIDTH_SAT = (64'd1 << W_BITS) - 1;
    localparam longint unsigned PTD_SAT   = 64'd65536;

    typedef struct packed {
        logic [W_BITS-1:0]   tot_w;
        logic [W_BITS-1:0]   chg_w;
        logic [W_BITS-1:0]   neu_w;
        logic [PTD_BITS-1:0] ptd;
        logic                tot_v;
        logic                chg_v;
        logic                neu_v;
        logic                ptd_v;
    } jet_shape_t;

    typedef struct packed {
        logic [15:0]            repeat_n;
        logic [PT_BITS-1:0]     pt;
        logic [ANGLE_BITS-1:0]  deta;
        logic [ANGLE_BITS-1:0]  dphi;
        logic                   chg;
        logic                   neu;
        logic                   last;
        logic                   typed;    // expected shape written out below
        jet_shape_t             shape;
    } request_row_t;

    localparam jet_shape_t NO_SHAPE  = '0;
    localparam jet_shape_t UNIT_CHG  = '{0, 0, 0, 17'd65536, 1, 1, 0, 1};
    localparam jet_shape_t ETA_ONE   = '{20'd256, 0, 0, 17'd65536, 1, 0, 0, 1};
    localparam jet_shape_t PHI_ONE_N = '{20'd256, 0, 20'd256, 17'd65536, 1, 0, 1, 1};

    // Directed plan: single-constituent jets whose result is obvious, extreme
    // offsets, zero-pt jets, both and neither flags, and long full-scale jets,
    // one of which drives every sum into saturation.
    request_row_t directed_plan [N_DIRECTED] = '{
        '{16'd1, 16'd0,     12'd0,    12'd0,    0, 0, 1, 1, NO_SHAPE},
        '{16'd1, 16'd1,     12'd0,    12'd0,    1, 0, 1, 1, UNIT_CHG},
        '{16'd1, 16'd1,     12'd1,    12'd0,    0, 0, 1, 1, ETA_ONE},
        '{16'd1, 16'd1,     12'd0,    12'd1,    0, 1, 1, 1, PHI_ONE_N},
        '{16'd1, 16'd65535, 12'h7ff,  12'h800,  1, 1, 0, 0, NO_SHAPE},
        '{16'd1, 16'd65535, 12'h800,  12'h7ff,  0, 0, 1, 0, NO_SHAPE},
        '{16'd1, 16'd0,     12'hfff,  12'hfff,  1, 1, 0, 0, NO_SHAPE},
        '{16'd1, 16'd0,     12'd5,    12'd5,    0, 1, 1, 1, NO_SHAPE},
        '{16'd1, 16'd100,   12'h800,  12'h800,  0, 1, 0, 0, NO_SHAPE},
        '{16'd1, 16'd300,   12'd7,    12'hff7,  1, 0, 0, 0, NO_SHAPE},
        '{16'd1, 16'd65535, 12'd0,    12'd0,    0, 0, 1, 0, NO_SHAPE},
        '{16'd70, 16'd65535, 12'h800, 12'h800,  1, 1, 0, 0, NO_SHAPE},
        '{16'd1, 16'd65535, 12'h800,  12'h800,  1, 1, 1, 0, NO_SHAPE},
        '{16'd80, 16'd65535, 12'd0,   12'd0,    0, 0, 0, 0, NO_SHAPE},
        '{16'd1, 16'd65535, 12'd3,    12'd0,    1, 0, 1, 0, NO_SHAPE},
        '{16'd1, 16'd1,     12'hfff,  12'd1,    1, 1, 0, 0, NO_SHAPE},
        '{16'd1, 16'd2,     12'h555,  12'haaa,  0, 1, 0, 0, NO_SHAPE},
        '{16'd1, 16'd3,     12'haaa,  12'h555,  1, 0, 1, 0, NO_SHAPE},
        '{16'd1, 16'h5555,  12'h001,  12'h7fe,  1, 1, 1, 0, NO_SHAPE},
        '{16'd1, 16'haaaa,  12'h801,  12'h002,  0, 0, 1, 0, NO_SHAPE}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [PT_BITS-1:0]           constituent_pt;
    logic signed [ANGLE_BITS-1:0] delta_eta;
    logic signed [ANGLE_BITS-1:0] delta_phi;
    logic                         is_charged;
    logic                         is_neutral;
    logic                         last_constituent;
    logic                         out_valid;
    logic                         out_stall;
    logic [W_BITS-1:0]            total_width;
    logic [W_BITS-1:0]            charged_width;
    logic [W_BITS-1:0]            neutral_width;
    logic [PTD_BITS-1:0]          pt_dispersion;
    logic                         total_valid;
    logic                         charged_valid;
    logic                         neutral_valid;
    logic                         dispersion_valid;

    // Running sums of the jet being streamed: index 0 all, 1 charged, 2 neutral.
    longint unsigned eta_moment [NCLASS];
    longint unsigned phi_moment [NCLASS];
    longint unsigned pt_sq_sum  [NCLASS];
    longint unsigned pt_total;

    jet_shape_t shapes_due [$];
    int         fail_count;
    int         jets_seen;
    int         idle_pct;
    int         stall_pct;
    int         quiet_cycles;

    jet_width_and_pt_dispersion_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                                longint unsigned lim);
        return (a + b > lim) ? lim : a + b;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // floor(num * 2^fbits / den), clamped at 2^cap_bits
    function automatic longint unsigned fixed_quotient(longint unsigned num,
                                                       longint unsigned den,
                                                       int fbits, int cap_bits);
        longint unsigned q;
        longint unsigned r;
        longint unsigned cap;
        q   = num / den;
        r   = num % den;
        cap = 64'd1 << cap_bits;
        if (q >= (cap >> fbits))
            return cap;
        for (int i = 0; i < fbits; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return (q > cap) ? cap : q;
    endfunction

    function automatic longint unsigned offset_square(logic signed [ANGLE_BITS-1:0] a);
        longint signed v;
        v = a;
        if (v < 0)
            v = -v;
        return v * v;
    endfunction

    function automatic logic [W_BITS-1:0] class_width(int k, output logic ok);
        longint unsigned w;
        ok = (pt_sq_sum[k] != 0);
        if (!ok)
            return '0;
        w = root_floor(fixed_quotient(eta_moment[k] + phi_moment[k], pt_sq_sum[k], 16, 60));
        return (w > WIDTH_SAT) ? W_BITS'(WIDTH_SAT) : W_BITS'(w);
    endfunction

    function automatic void clear_jet_sums();
        for (int k = 0; k < NCLASS; k++)
        begin
            eta_moment[k] = 0;
            phi_moment[k] = 0;
            pt_sq_sum[k]  = 0;
        end
        pt_total = 0;
    endfunction

    // Fold one accepted constituent into the sums; on the last one return the
    // predicted jet shape and clear for the next jet.
    function automatic bit accumulate_constituent(logic [PT_BITS-1:0] pt,
                                                  logic signed [ANGLE_BITS-1:0] deta,
                                                  logic signed [ANGLE_BITS-1:0] dphi,
                                                  logic chg, logic neu, logic last,
                                                  output jet_shape_t shape);
        longint unsigned p2;
        longint unsigned me;
        longint unsigned mp;
        longint unsigned d;
        bit              member [NCLASS];
        p2 = longint'(pt) * longint'(pt);
        me = p2 * offset_square(deta);     // at most 2^55, never saturates alone
        mp = p2 * offset_square(dphi);
        member[CLS_ALL]     = 1'b1;
        member[CLS_CHARGED] = chg;
        member[CLS_NEUTRAL] = neu;
        for (int k = 0; k < NCLASS; k++)
        begin
            if (member[k])
            begin
                eta_moment[k] = sat_sum(eta_moment[k], me, MOM_SAT);
                phi_moment[k] = sat_sum(phi_moment[k], mp, MOM_SAT);
                pt_sq_sum[k]  = sat_sum(pt_sq_sum[k], p2, PT2_SAT);
            end
        end
        pt_total = sat_sum(pt_total, longint'(pt), PTSUM_SAT);
        shape = '0;
        if (!last)
            return 1'b0;
        shape.tot_w = class_width(CLS_ALL, shape.tot_v);
        shape.chg_w = class_width(CLS_CHARGED, shape.chg_v);
        shape.neu_w = class_width(CLS_NEUTRAL, shape.neu_v);
        if (pt_total != 0)
        begin
            d = root_floor(fixed_quotient(pt_sq_sum[CLS_ALL], pt_total * pt_total, 32, 32));
            shape.ptd   = (d > PTD_SAT) ? PTD_BITS'(PTD_SAT) : PTD_BITS'(d);
            shape.ptd_v = 1'b1;
        end
        clear_jet_sums();
        return 1'b1;
    endfunction

    // Present one constituent request, idling first at random; hold it until
    // accepted, then predict.
    task automatic send_constituent(logic [PT_BITS-1:0] pt,
                                    logic signed [ANGLE_BITS-1:0] deta,
                                    logic signed [ANGLE_BITS-1:0] dphi,
                                    logic chg, logic neu, logic last,
                                    bit typed, jet_shape_t typed_shape);
        jet_shape_t shape;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        constituent_pt   <= pt;
        delta_eta        <= deta;
        delta_phi        <= dphi;
        is_charged       <= chg;
        is_neutral       <= neu;
        last_constituent <= last;
        do
            @(posedge clk);
        while (in_stall);
        if (accumulate_constituent(pt, deta, dphi, chg, neu, last, shape))
        begin
            shapes_due.push_back(typed ? typed_shape : shape);
            jets_seen++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shapes_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Result side: check each accepted result against the oldest prediction,
    // then choose the stall for the next cycle.
    always @(posedge clk)
    begin
        jet_shape_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (shapes_due.size() == 0)
            begin
                $display("%0t: unexpected result, total_width %0d", $time, total_width);
                fail_count++;
            end
            else
            begin
                want = shapes_due.pop_front();
                compare_field("total_width", want.tot_w, total_width);
                compare_field("charged_width", want.chg_w, charged_width);
                compare_field("neutral_width", want.neu_w, neutral_width);
                compare_field("pt_dispersion", want.ptd, pt_dispersion);
                compare_field("total_valid", want.tot_v, total_valid);
                compare_field("charged_valid", want.chg_v, charged_valid);
                compare_field("neutral_valid", want.neu_v, neutral_valid);
                compare_field("dispersion_valid", want.ptd_v, dispersion_valid);
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("jet_width_and_pt_dispersion_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        int                           items;
        int                           jet_len;
        int                           pick;
        logic [PT_BITS-1:0]           pt;
        logic signed [ANGLE_BITS-1:0] deta;
        logic signed [ANGLE_BITS-1:0] dphi;

        in_valid         = 1'b0;
        constituent_pt   = '0;
        delta_eta        = '0;
        delta_phi        = '0;
        is_charged       = 1'b0;
        is_neutral       = 1'b0;
        last_constituent = 1'b0;
        fail_count       = 0;
        jets_seen        = 0;
        idle_pct         = 0;
        stall_pct        = 0;
        clear_jet_sums();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: walk the plan with no idling.
        foreach (directed_plan[i])
        begin
            for (int n = 0; n < directed_plan[i].repeat_n; n++)
                send_constituent(directed_plan[i].pt, directed_plan[i].deta,
                                 directed_plan[i].dphi, directed_plan[i].chg,
                                 directed_plan[i].neu, directed_plan[i].last,
                                 directed_plan[i].typed, directed_plan[i].shape);
        end

        // Hold the sender until every directed result is back.
        drain_results();

        // Random jets, in four idling phases. Most jets are short so the back
        // end, not the stream, sets the pace; some run to 90 constituents.
        items = 0;
        while (items < RANDOM_ITEMS || jets_seen < MIN_JETS + N_DIRECTED)
        begin
            case ((items * 4 / RANDOM_ITEMS) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            pick = $urandom_range(99);
            jet_len = (pick < 80) ? $urandom_range(1, 24) :
                      (pick < 96) ? $urandom_range(25, 60) : $urandom_range(61, 90);
            for (int n = 0; n < jet_len; n++)
            begin
                pick = $urandom_range(9);
                pt = (pick == 0) ? '0 : (pick == 1) ? '1 :
                     (pick < 4) ? PT_BITS'($urandom_range(255)) : PT_BITS'($urandom);
                pick = $urandom_range(9);
                deta = (pick == 0) ? 12'h800 : (pick == 1) ? 12'h7ff :
                       ANGLE_BITS'($urandom);
                dphi = ($urandom_range(9) == 0) ? 12'h800 : ANGLE_BITS'($urandom);
                send_constituent(pt, deta, dphi, 1'($urandom), 1'($urandom),
                                 n == jet_len - 1, 1'b0, NO_SHAPE);
                items++;
            end
            // Occasionally pause until the pipe is empty mid-run.
            if ($urandom_range(29) == 0)
                drain_results();
        end

        in_valid <= 1'b0;
        while (shapes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && shapes_due.size() == 0)
            $display("jet_width_and_pt_dispersion_unit verification clean");
        else
            $display("jet_width_and_pt_dispersion_unit verification failed");
        $finish;
    end

endmodule
